/* src/bpdc_pkg.sv */
// Shared types, register codes and reset constants for the button and display controller.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

    localparam int TIME_W      = 32;
    localparam int IDLE_W      = 8;
    localparam int MS_W        = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MAX_MS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS_MS  = 2'd3;

    // Register values after reset.
    localparam logic [IDLE_W-1:0] SLEEP_TICKS_RST   = 8'd30;
    localparam logic [MS_W-1:0]   LONG_PRESS_MS_RST = 16'd10000;
    localparam logic [MS_W-1:0]   SHORT_MAX_MS_RST  = 16'd7500;
    localparam logic [MS_W-1:0]   MIN_PRESS_MS_RST  = 16'd100;

    // Event kinds.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // Button pin levels.
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // Card actions.
    localparam logic [1:0] CARD_NONE    = 2'd0;
    localparam logic [1:0] CARD_MOUNT   = 2'd1;
    localparam logic [1:0] CARD_UNMOUNT = 2'd2;

    typedef struct packed {
        logic              op;
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
        logic              pairing_busy;
        logic              card_mounted;
    } evt_t;

    typedef struct packed {
        logic       refresh_display;
        logic       display_enable;
        logic       display_disable;
        logic       start_wps;
        logic [1:0] card_action;
        logic       display_on;
    } res_t;

    typedef struct packed {
        logic [IDLE_W-1:0] sleep_ticks;
        logic [MS_W-1:0]   long_press_ms;
        logic [MS_W-1:0]   short_max_ms;
        logic [MS_W-1:0]   min_press_ms;
    } cfg_t;

endpackage

`default_nettype wire

/* src/bpdc_if.sv */
// Valid/ready channel interfaces for event beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_evt_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        button_level;
    logic [31:0] now_ms;
    logic        pairing_busy;
    logic        card_mounted;

    modport source (output valid, op, button_level, now_ms, pairing_busy, card_mounted,
                    input ready);
    modport sink   (input valid, op, button_level, now_ms, pairing_busy, card_mounted,
                    output ready);
endinterface

interface bpdc_res_if;
    logic       valid;
    logic       ready;
    logic       refresh_display;
    logic       display_enable;
    logic       display_disable;
    logic       start_wps;
    logic [1:0] card_action;
    logic       display_on;

    modport source (output valid, refresh_display, display_enable, display_disable,
                    start_wps, card_action, display_on, input ready);
    modport sink   (input valid, refresh_display, display_enable, display_disable,
                    start_wps, card_action, display_on, output ready);
endinterface

`default_nettype wire

/* src/bpdc_cfg_regs.sv */
// Configuration register file with its write port.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_cfg_regs
    import bpdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SLEEP_TICKS:   cfg_next.sleep_ticks   = cfg_data[IDLE_W-1:0];
                REG_LONG_PRESS_MS: cfg_next.long_press_ms = cfg_data[MS_W-1:0];
                REG_SHORT_MAX_MS:  cfg_next.short_max_ms  = cfg_data[MS_W-1:0];
                REG_MIN_PRESS_MS:  cfg_next.min_press_ms  = cfg_data[MS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_ticks   <= SLEEP_TICKS_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_MS_RST;
            cfg_reg.short_max_ms  <= SHORT_MAX_MS_RST;
            cfg_reg.min_press_ms  <= MIN_PRESS_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/bpdc_step.sv */
// Controller state and the combinational decision logic for one event.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_step
    import bpdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire evt_t evt,
    input  wire cfg_t cfg,
    output res_t      res
);

    logic [IDLE_W-1:0] idle_count_reg, idle_count_next;
    logic              display_off_reg, display_off_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] duration;

    // Hold time, wrapping with the timestamp.
    assign duration = evt.now_ms - press_start_reg;

    always_comb
    begin
        idle_count_next  = idle_count_reg;
        display_off_next = display_off_reg;
        held_next        = held_reg;
        press_start_next = press_start_reg;
        res              = '0;

        if (evt.op == OP_TICK)
        begin
            if (idle_count_reg < cfg.sleep_ticks)
            begin
                res.refresh_display = 1'b1;
                priority if (evt.pairing_busy)
                begin
                    idle_count_next = '0;
                end
                else if (held_reg)
                begin
                    idle_count_next = '0;
                    res.start_wps   = (duration > {16'd0, cfg.long_press_ms});
                end
                else
                begin
                    idle_count_next = idle_count_reg + 1'b1;
                end
            end
            else if (!display_off_reg)
            begin
                res.display_disable = 1'b1;
                display_off_next    = 1'b1;
            end
        end
        else if (evt.button_level == LEVEL_PRESSED)
        begin
            held_next        = 1'b1;
            press_start_next = evt.now_ms;
        end
        else
        begin
            held_next = 1'b0;
            if (duration >= {16'd0, cfg.min_press_ms})
            begin
                if (!display_off_reg)
                begin
                    if ((duration != '0) && (duration < {16'd0, cfg.short_max_ms}))
                    begin
                        res.card_action = evt.card_mounted ? CARD_UNMOUNT : CARD_MOUNT;
                    end
                end
                else
                begin
                    display_off_next   = 1'b0;
                    idle_count_next    = '0;
                    res.display_enable = 1'b1;
                end
            end
        end

        res.display_on = !display_off_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_count_reg  <= '0;
            display_off_reg <= 1'b0;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
        end
        else if (advance)
        begin
            idle_count_reg  <= idle_count_next;
            display_off_reg <= display_off_next;
            held_reg        <= held_next;
            press_start_reg <= press_start_next;
        end
    end

    // Once off, a tick never turns the display back on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && evt.op == OP_TICK && display_off_reg) |=> display_off_reg)
        else $error("tick switched the display on");

    // The idle count only steps by one or restarts from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idle_count_next != idle_count_reg) |=>
        (idle_count_reg == '0 || idle_count_reg == $past(idle_count_reg) + 1'b1))
        else $error("idle count jumped");

    // A press records the timestamp of the beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && evt.op == OP_BUTTON && evt.button_level == LEVEL_PRESSED) |=>
        (held_reg && press_start_reg == $past(evt.now_ms)))
        else $error("press not recorded");

endmodule

`default_nettype wire

/* src/button_press_display_controller.sv */
// Top level of the button and display controller: event register, step logic, result register.
//
//  Channel  | Modport | Payload                                             | Beat
//  ---------+---------+-----------------------------------------------------+----------------
//  evt      | sink    | op, button_level, now_ms, pairing_busy, card_mounted| valid & ready
//  res      | source  | refresh_display, display_enable, display_disable,   | valid & ready
//           |         | start_wps, card_action, display_on                  |
//  cfg      | write   | cfg_write_en, cfg_index, cfg_data                   | cfg_write_en
//
//  Every event beat yields exactly one result beat, by way of the event register and then the result register.
//  Throughput is one beat per cycle while the result is taken: the step logic reads the event register and
//  the controller state and writes the result register in the same cycle.
//  Reset (rst_n low, asynchronous) clears both valid flags, the controller state
//  and loads the register defaults. A stalled result holds the result register;
//  the event register then fills and evt.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module button_press_display_controller
    import bpdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bpdc_evt_if.sink                    evt,
    bpdc_res_if.source                  res,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    // Event register. It only holds payload; its valid flag is control state.
    logic evt_valid_reg, evt_valid_next;
    evt_t evt_reg, evt_next;

    // Result register.
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    logic evt_take;
    logic advance;

    bpdc_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // The registered event moves on whenever the result register is free or being drained.
    assign advance  = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;

    bpdc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .evt     (evt_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_comb
    begin
        evt_next.op           = evt.op;
        evt_next.button_level = evt.button_level;
        evt_next.now_ms       = evt.now_ms;
        evt_next.pairing_busy = evt.pairing_busy;
        evt_next.card_mounted = evt.card_mounted;

        evt_valid_next = evt_take || (evt_valid_reg && !advance);
        res_valid_next = advance || (res_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg <= evt_next;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.refresh_display = res_reg.refresh_display;
    assign res.display_enable  = res_reg.display_enable;
    assign res.display_disable = res_reg.display_disable;
    assign res.start_wps       = res_reg.start_wps;
    assign res.card_action     = res_reg.card_action;
    assign res.display_on      = res_reg.display_on;

    // Enable and disable never come in the same beat, and each agrees with display_on.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!(res_reg.display_enable && res_reg.display_disable)
                           && (!res_reg.display_enable || res_reg.display_on)
                           && (!res_reg.display_disable || !res_reg.display_on)))
        else $error("display switch disagrees with display state");

    // Card actions only happen with the display on, and the unused code never shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.card_action != CARD_NONE) |->
        (res_reg.display_on && (res_reg.card_action == CARD_MOUNT
                                || res_reg.card_action == CARD_UNMOUNT)))
        else $error("bad card action");

    // A WPS request only comes from a refreshing tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.start_wps) |-> res_reg.refresh_display)
        else $error("WPS request without refresh");

    // A registered event that moves on shows up as a valid result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result beat lost");

endmodule

`default_nettype wire
